[rtl/rvn_pkg.sv]
// rvn_pkg: types, widths and helpers for the vector reflection pipeline
// no dependencies; imported by every rtl module of the block
package rvn_pkg;

   localparam int FRAC_BITS = 16;
   localparam int FW        = 24;
   localparam int THR_W     = 23;
   localparam int THR_RESET = 16;
   localparam int SW        = 2 * FW;
   localparam int RT_W      = SW / 2;
   localparam int NW        = FW + FRAC_BITS;
   localparam int QW        = FRAC_BITS + 1;
   localparam int NHW       = QW + 1;
   localparam int PW        = FW + NHW;
   localparam int DW        = PW + 2;
   localparam int DQW       = DW - FRAC_BITS + 1;
   localparam int MW        = DQW + NHW;

   localparam logic signed [63:0] MAX_VAL = 64'sd8388607;
   localparam logic signed [63:0] MIN_VAL = -64'sd8388608;

   typedef struct packed {
      logic signed [FW-1:0] vec_x;
      logic signed [FW-1:0] vec_y;
      logic signed [FW-1:0] vec_z;
      logic signed [FW-1:0] normal_x;
      logic signed [FW-1:0] normal_y;
      logic signed [FW-1:0] normal_z;
   } req_type;

   typedef struct packed {
      logic signed [FW-1:0] refl_x;
      logic signed [FW-1:0] refl_y;
      logic signed [FW-1:0] refl_z;
      logic                 degenerate_normal;
      logic                 saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [FW-1:0] vx;
      logic signed [FW-1:0] vy;
      logic signed [FW-1:0] vz;
      logic [2:0]           nneg;
      logic                 degen;
   } div_side_type;

   // divide by 2^FRAC_BITS, nearest, ties away from zero
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x);
      logic [63:0] m;
      logic [63:0] q;
      begin
         m = x[63] ? (64'd0 - 64'(x)) : 64'(x);
         q = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         rnd_shift = x[63] ? -$signed(q) : $signed(q);
      end
   endfunction

endpackage

[rtl/rvn_sqrt_pipe.sv]
// rvn_sqrt_pipe: integer square root, one root bit per register stage
// depends on rvn_pkg
module rvn_sqrt_pipe
   import rvn_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [SW-1:0]   in_s,
   input  req_type         in_side,
   output logic            out_valid,
   output logic [RT_W-1:0] out_root,
   output req_type         out_side
);

   localparam int RW = RT_W + 3;

   logic [RW-1:0]   rem_ff  [RT_W];
   logic [RT_W-1:0] root_ff [RT_W];
   logic [SW-1:0]   s_ff    [RT_W];
   req_type         side_ff [RT_W];
   logic            vld_ff  [RT_W];

   genvar k;
   generate
      for (k = 0; k < RT_W; k++) begin : g_stage
         logic [RW-1:0]   rem_prev;
         logic [RT_W-1:0] root_prev;
         logic [SW-1:0]   s_prev;
         req_type         side_prev;
         logic            vld_prev;
         logic [RW-1:0]   rem_sh;
         logic [RW-1:0]   trial;
         logic [RW-1:0]   rem_in;
         logic [RT_W-1:0] root_in;

         if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign s_prev    = in_s;
            assign side_prev = in_side;
            assign vld_prev  = in_valid;
         end else begin : g_next
            assign rem_prev  = rem_ff[k-1];
            assign root_prev = root_ff[k-1];
            assign s_prev    = s_ff[k-1];
            assign side_prev = side_ff[k-1];
            assign vld_prev  = vld_ff[k-1];
         end

         always_comb begin
            rem_sh = {rem_prev[RW-3:0], s_prev[SW-1-2*k -: 2]};
            trial  = RW'({root_prev, 2'b01});
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_prev[RT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_prev[RT_W-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (en) begin
               vld_ff[k] <= vld_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
               s_ff[k]    <= s_prev;
               side_ff[k] <= side_prev;
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[RT_W-1];
   assign out_root  = root_ff[RT_W-1];
   assign out_side  = side_ff[RT_W-1];

endmodule

[rtl/rvn_div_pipe.sv]
// rvn_div_pipe: three-lane restoring divider, one quotient bit per stage
// depends on rvn_pkg
module rvn_div_pipe
   import rvn_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num [3],
   input  logic [FW-1:0] in_den,
   input  div_side_type  in_side,
   output logic          out_valid,
   output logic [QW-1:0] out_q [3],
   output div_side_type  out_side
);

   logic [FW-1:0] rem_ff  [QW][3];
   logic [QW-1:0] q_ff    [QW][3];
   logic [NW-1:0] num_ff  [QW][3];
   logic [FW-1:0] den_ff  [QW];
   div_side_type  side_ff [QW];
   logic          vld_ff  [QW];

   genvar k, j;
   generate
      for (k = 0; k < QW; k++) begin : g_stage
         logic [FW-1:0] den_prev;
         div_side_type  side_prev;
         logic          vld_prev;

         if (k == 0) begin : g_first
            assign den_prev  = in_den;
            assign side_prev = in_side;
            assign vld_prev  = in_valid;
         end else begin : g_next
            assign den_prev  = den_ff[k-1];
            assign side_prev = side_ff[k-1];
            assign vld_prev  = vld_ff[k-1];
         end

         for (j = 0; j < 3; j++) begin : g_lane
            logic [FW-1:0] rem_prev;
            logic [QW-1:0] q_prev;
            logic [NW-1:0] num_prev;
            logic [FW:0]   rs;
            logic [FW-1:0] rem_in;
            logic [QW-1:0] q_in;

            if (k == 0) begin : g_first
               assign rem_prev = FW'(in_num[j][NW-1:QW]);
               assign q_prev   = '0;
               assign num_prev = in_num[j];
            end else begin : g_next
               assign rem_prev = rem_ff[k-1][j];
               assign q_prev   = q_ff[k-1][j];
               assign num_prev = num_ff[k-1][j];
            end

            always_comb begin
               rs = {rem_prev, num_prev[QW-1-k]};
               if (rs >= {1'b0, den_prev}) begin
                  rem_in = FW'(rs - {1'b0, den_prev});
                  q_in   = {q_prev[QW-2:0], 1'b1};
               end else begin
                  rem_in = rs[FW-1:0];
                  q_in   = {q_prev[QW-2:0], 1'b0};
               end
            end

            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[k][j] <= rem_in;
                  q_ff[k][j]   <= q_in;
                  num_ff[k][j] <= num_prev;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[k] <= 1'b0;
            end else if (en) begin
               vld_ff[k] <= vld_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               den_ff[k]  <= den_prev;
               side_ff[k] <= side_prev;
            end
         end
      end
   endgenerate

   assign out_valid = vld_ff[QW-1];
   assign out_q     = q_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

[rtl/vector_reflect_about_normal_top.sv]
// Reflects a Q8.16 vector about a normal of any length: R = 2*dot(v, n_hat)*n_hat - v,
// saturated; a normal whose length is below zero_threshold (or zero) yields R = -v.
// Fully pipelined: one transaction per cycle unless the output stalls, and a stall
// freezes the whole pipeline, whose depth is set by the 24-stage square root and the
// 17-stage divider. zero_threshold must be written via csr port while idle; unenforced.
// depends on rvn_pkg, rvn_sqrt_pipe, rvn_div_pipe
module vector_reflect_about_normal_top
   import rvn_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [THR_W-1:0] csr_data
);

   logic             en;
   logic [THR_W-1:0] thr_ff;

   logic             a_vld_ff;
   req_type          a_req_ff;
   logic [SW-1:0]    a_sq_ff [3];
   logic             b_vld_ff;
   req_type          b_req_ff;
   logic [SW-1:0]    b_s_ff;

   logic             sq_vld;
   logic [RT_W-1:0]  sq_root;
   req_type          sq_side;

   logic             c_vld_ff;
   logic [NW-1:0]    c_num_ff [3];
   logic [FW-1:0]    c_den_ff;
   div_side_type     c_side_ff;
   logic [NW-1:0]    c_num_in [3];
   div_side_type     c_side_in;

   logic             dv_vld;
   logic [QW-1:0]    dv_q [3];
   div_side_type     dv_side;

   logic                  d_vld_ff, e_vld_ff, f_vld_ff;
   logic signed [NHW-1:0] d_nh_ff [3];
   logic signed [PW-1:0]  d_p_ff [3];
   div_side_type          d_side_ff;
   logic signed [NHW-1:0] d_nh_in [3];
   logic signed [NHW-1:0] e_nh_ff [3];
   logic signed [DQW-1:0] e_dq_ff;
   div_side_type          e_side_ff;
   logic signed [MW-1:0]  f_m_ff [3];
   div_side_type          f_side_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_W'(THR_RESET);
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   // squares and sum
   always_ff @(posedge clock) begin
      if (en) begin
         a_req_ff   <= req_data;
         a_sq_ff[0] <= SW'(req_data.normal_x * req_data.normal_x);
         a_sq_ff[1] <= SW'(req_data.normal_y * req_data.normal_y);
         a_sq_ff[2] <= SW'(req_data.normal_z * req_data.normal_z);
         b_req_ff   <= a_req_ff;
         b_s_ff     <= a_sq_ff[0] + a_sq_ff[1] + a_sq_ff[2];
      end
   end

   rvn_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_vld_ff),
      .in_s      (b_s_ff),
      .in_side   (b_req_ff),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // degenerate test and dividend setup
   always_comb begin
      logic [FW-1:0] an [3];
      logic signed [FW-1:0] nn [3];
      nn[0] = sq_side.normal_x;
      nn[1] = sq_side.normal_y;
      nn[2] = sq_side.normal_z;
      for (int i = 0; i < 3; i++) begin
         an[i] = nn[i][FW-1] ? FW'(-nn[i]) : FW'(nn[i]);
         c_num_in[i] = {an[i], {FRAC_BITS{1'b0}}} + NW'(sq_root >> 1);
         c_side_in.nneg[i] = nn[i][FW-1];
      end
      c_side_in.vx    = sq_side.vec_x;
      c_side_in.vy    = sq_side.vec_y;
      c_side_in.vz    = sq_side.vec_z;
      c_side_in.degen = (sq_root == '0) || (sq_root < RT_W'(thr_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_num_ff  <= c_num_in;
         c_den_ff  <= FW'(sq_root);
         c_side_ff <= c_side_in;
      end
   end

   rvn_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_vld_ff),
      .in_num    (c_num_ff),
      .in_den    (c_den_ff),
      .in_side   (c_side_ff),
      .out_valid (dv_vld),
      .out_q     (dv_q),
      .out_side  (dv_side)
   );

   // signed unit normal and dot product terms
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_nh_in[i] = dv_side.nneg[i] ? -$signed({1'b0, dv_q[i]}) : $signed({1'b0, dv_q[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_nh_ff   <= d_nh_in;
         d_p_ff[0] <= PW'(dv_side.vx * d_nh_in[0]);
         d_p_ff[1] <= PW'(dv_side.vy * d_nh_in[1]);
         d_p_ff[2] <= PW'(dv_side.vz * d_nh_in[2]);
         d_side_ff <= dv_side;
      end
   end

   // rounded dot product
   always_ff @(posedge clock) begin
      if (en) begin
         e_nh_ff   <= d_nh_ff;
         e_dq_ff   <= DQW'(rnd_shift(64'(d_p_ff[0]) + 64'(d_p_ff[1]) + 64'(d_p_ff[2])));
         e_side_ff <= d_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            f_m_ff[i] <= MW'(e_dq_ff * e_nh_ff[i]);
         end
         f_side_ff <= e_side_ff;
      end
   end

   // scale, subtract and clamp
   always_comb begin
      logic signed [63:0] vv [3];
      logic signed [63:0] r;
      logic signed [FW-1:0] rc [3];
      logic sat;
      vv[0] = 64'(f_side_ff.vx);
      vv[1] = 64'(f_side_ff.vy);
      vv[2] = 64'(f_side_ff.vz);
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (f_side_ff.degen) begin
            r = -vv[i];
         end else begin
            r = rnd_shift(64'(f_m_ff[i]) <<< 1) - vv[i];
         end
         if (r > MAX_VAL) begin
            rc[i] = FW'(MAX_VAL);
            sat   = 1'b1;
         end else if (r < MIN_VAL) begin
            rc[i] = FW'(MIN_VAL);
            sat   = 1'b1;
         end else begin
            rc[i] = FW'(r);
         end
      end
      rsp_data_in.refl_x            = rc[0];
      rsp_data_in.refl_y            = rc[1];
      rsp_data_in.refl_z            = rc[2];
      rsp_data_in.degenerate_normal = f_side_ff.degen;
      rsp_data_in.saturated         = sat;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff     <= 1'b0;
         b_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         d_vld_ff     <= 1'b0;
         e_vld_ff     <= 1'b0;
         f_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff     <= req_valid;
         b_vld_ff     <= a_vld_ff;
         c_vld_ff     <= sq_vld;
         d_vld_ff     <= dv_vld;
         e_vld_ff     <= d_vld_ff;
         f_vld_ff     <= e_vld_ff;
         rsp_valid_ff <= f_vld_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[dv/tb.sv]
// tb: self-checking testbench for vector_reflect_about_normal_top, reflection of a
// Q8.16 vector about a normal, with a directed table, random bursts and a predictor
// depends on rvn_pkg and the rtl of the block
module tb;
   import rvn_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [THR_W-1:0] csr_data = '0;

   rsp_type          refl_queue[$];
   logic [THR_W-1:0] threshold;
   int               error_count = 0;
   int               cycle_count = 0;
   int               hold_off = 0;
   bit               done = 1'b0;

   localparam int LIMIT = 400000;

   vector_reflect_about_normal_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   function automatic longint abs64(input longint x);
      return x < 0 ? -x : x;
   endfunction

   function automatic longint round_frac(input longint x);
      longint m;
      m = (abs64(x) + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      return x < 0 ? -m : m;
   endfunction

   function automatic longint clamp_q(input longint x, inout bit sat);
      if (x > 64'sd8388607) begin
         sat = 1'b1;
         return 64'sd8388607;
      end
      if (x < -64'sd8388608) begin
         sat = 1'b1;
         return -64'sd8388608;
      end
      return x;
   endfunction

   function automatic rsp_type reflect(input req_type r, input logic [THR_W-1:0] thr);
      longint    v[3], n[3], nh[3], res[3];
      longint    d, dq, t;
      longint    len, q;
      longint unsigned s, bitv, rem, root;
      bit        degen, sat;
      rsp_type   o;
      v[0] = r.vec_x; v[1] = r.vec_y; v[2] = r.vec_z;
      n[0] = r.normal_x; n[1] = r.normal_y; n[2] = r.normal_z;
      s = 0;
      sat = 1'b0;
      for (int i = 0; i < 3; i++) s += longint'(n[i] * n[i]);
      rem = s;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      len = longint'(root);
      degen = (len == 0) || (len < longint'(thr));
      if (degen) begin
         for (int i = 0; i < 3; i++) res[i] = clamp_q(-v[i], sat);
      end else begin
         d = 0;
         for (int i = 0; i < 3; i++) begin
            q = ((abs64(n[i]) <<< FRAC_BITS) + (len >>> 1)) / len;
            nh[i] = n[i] < 0 ? -q : q;
            d += v[i] * nh[i];
         end
         dq = round_frac(d);
         for (int i = 0; i < 3; i++) begin
            t = round_frac(2 * dq * nh[i]);
            res[i] = clamp_q(t - v[i], sat);
         end
      end
      o.refl_x = res[0][FW-1:0];
      o.refl_y = res[1][FW-1:0];
      o.refl_z = res[2][FW-1:0];
      o.degenerate_normal = degen;
      o.saturated = sat;
      return o;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (refl_queue.size() == 0) begin
            report("unexpected transaction", 1, 0);
         end else begin
            e = refl_queue.pop_front();
            if (rsp_data.refl_x !== e.refl_x) report("refl_x", rsp_data.refl_x, e.refl_x);
            if (rsp_data.refl_y !== e.refl_y) report("refl_y", rsp_data.refl_y, e.refl_y);
            if (rsp_data.refl_z !== e.refl_z) report("refl_z", rsp_data.refl_z, e.refl_z);
            if (rsp_data.degenerate_normal !== e.degenerate_normal)
               report("degenerate_normal", rsp_data.degenerate_normal, e.degenerate_normal);
            if (rsp_data.saturated !== e.saturated)
               report("saturated", rsp_data.saturated, e.saturated);
         end
      end
   end

   // receiver stall pattern plus long hold-off
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else if (cycle_count % 512 < 160) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT && !done) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   task automatic send(input req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      refl_queue.push_back(reflect(r, threshold));
   endtask

   task automatic idle_gap(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain(input int extra);
      req_valid <= 1'b0;
      while (refl_queue.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      threshold = value;
   endtask

   function automatic logic signed [FW-1:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 24'sh800000;
         1: return 24'sh7fffff;
         2: return $signed(24'($urandom_range(0, 1 << 18))) - 24'sd131072;
         3: return 24'sh010000;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic req_type rand_req(input int mode);
      req_type r;
      r.vec_x = rand_comp(); r.vec_y = rand_comp(); r.vec_z = rand_comp();
      if (mode == 0) begin
         r.normal_x = 24'($urandom_range(0, 63)) - 24'sd32;
         r.normal_y = 24'($urandom_range(0, 63)) - 24'sd32;
         r.normal_z = 24'($urandom_range(0, 63)) - 24'sd32;
      end else begin
         r.normal_x = rand_comp(); r.normal_y = rand_comp(); r.normal_z = rand_comp();
      end
      return r;
   endfunction

   typedef struct {
      req_type r;
      bit      typed;
      rsp_type want;
   } stim_row_type;

   stim_row_type directed[$];

   function automatic stim_row_type row(input logic signed [FW-1:0] vx, vy, vz, nx, ny, nz,
                                        input bit typed, input rsp_type want);
      stim_row_type s;
      s.r = '{vx, vy, vz, nx, ny, nz};
      s.typed = typed;
      s.want = want;
      return s;
   endfunction

   initial begin
      rsp_type w;
      threshold = THR_W'(THR_RESET);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero normal, extremes, axis normals, sub-threshold normal
      directed.push_back(row(0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 1'b1, 1'b0}));
      directed.push_back(row(24'sh800000, 24'sh7fffff, 5, 0, 0, 0, 1,
                             '{24'sh7fffff, -24'sh7fffff, -5, 1'b1, 1'b1}));
      directed.push_back(row(24'sh010000, 0, 0, 3, 0, 0, 1,
                             '{-24'sh010000, 0, 0, 1'b1, 1'b0}));
      directed.push_back(row(24'sh010000, 24'sh020000, 24'sh030000, 24'sh010000, 0, 0,
                             1, '{24'sh010000, -24'sh020000, -24'sh030000, 1'b0, 1'b0}));
      directed.push_back(row(24'sh010000, 24'sh010000, 0, 0, 24'sh7fffff, 0, 0, '0));
      directed.push_back(row(24'sh7fffff, 24'sh7fffff, 24'sh7fffff,
                             24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 0, '0));
      directed.push_back(row(24'sh800000, 24'sh800000, 24'sh800000,
                             24'sh800000, 24'sh800000, 24'sh800000, 0, '0));
      directed.push_back(row(24'sh7fffff, 24'sh800000, 24'sh123456,
                             24'sh800000, 24'sh7fffff, 24'shfedcba, 0, '0));
      directed.push_back(row(24'sh400000, -24'sh400000, 0, 1, 1, 0, 0, '0));
      directed.push_back(row(-24'sh000001, 24'sh000001, 24'sh555555,
                             0, 0, 16, 0, '0));
      directed.push_back(row(24'sh0abcde, 24'sh0fedcb, -24'sh0abcde,
                             0, 0, 15, 0, '0));
      directed.push_back(row(24'sh2aaaaa, 24'sh555555, 24'shffffff,
                             24'sh000100, -24'sh000200, 24'sh000300, 0, '0));
      foreach (directed[i]) begin
         send(directed[i].r);
         if (directed[i].typed) begin
            w = refl_queue[$];
            if (w !== directed[i].want) report("directed row", i, 0);
         end
      end
      req_valid <= 1'b0;
      drain(0);

      // long receiver hold-off while the sender keeps offering
      hold_off = 300;
      repeat (120) send(rand_req(1));
      drain(60);

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_threshold('0);
            1: write_threshold(23'h7fffff);
            2: write_threshold(23'd40);
            3: write_threshold(23'd1000);
            default: write_threshold(THR_W'(THR_RESET));
         endcase
         for (int n = 0; n < 104; ) begin
            int burst;
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst; b++, n++)
               send(rand_req($urandom_range(0, 3) == 0 ? 0 : 1));
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
         end
         drain(60);
      end

      done = 1'b1;
      if (error_count == 0 && refl_queue.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule
